// ===== sv/brb_pkg.sv =====
// Package for the byte ring buffer: operation codes, field widths and the
// per-request result record shared by the index core and the top level.
// No dependencies.
`default_nettype none

package brb_pkg;

	localparam int OPCODE_W  = 2;
	localparam int BYTE_W    = 8;
	localparam int OFFSET_W  = 10;
	localparam int COUNT_W   = 11;
	localparam int FILL_W    = 10;
	localparam int CFG_W     = 11;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUT    = 2'd0,
		OP_PEEK   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// result of one request, minus the byte read from the store
	typedef struct packed {
		logic               peek_hit;
		logic               ok;
		logic [COUNT_W-1:0] removed;
		logic [FILL_W-1:0]  fill;
		logic               full;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/byte_ring_buffer_peek_skip_top.sv =====
// Top level of the byte ring buffer with peek and skip: request handshake,
// result register and read byte select. Depends on brb_pkg, brb_core, brb_store.
//
// Usage:
//   Request channel (in_valid/in_ready) carries opcode, data_byte,
//   peek_offset and remove_count: put, peek, remove or clear.
//   Result channel (out_valid/out_ready) returns one result per request:
//   read_byte, ok, removed, fill_count and full_res after the operation.
//   Config channel (cfg_valid/cfg_ready) writes buffer_size, clamped to
//   2..DEPTH; the write also empties the buffer. cfg_ready is always high;
//   write only while no request is outstanding.
//   Latency: a result is valid the cycle after its request is accepted.
//   Throughput: one request per cycle while no result is stalled; index
//   arithmetic and the store access of each request (at most one) happen on acceptance.
//   Stall: while a result waits with out_ready low, in_ready is low; it
//   rises in the cycle the result is taken.
//   Reset: buffer empty, buffer_size 1024 (or DEPTH if smaller), no result
//   pending. Store contents are undefined; peek never reads unwritten slots.
`default_nettype none

module byte_ring_buffer_peek_skip_top
	import brb_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [BYTE_W-1:0]   data_byte,
	input  wire logic [OFFSET_W-1:0] peek_offset,
	input  wire logic [COUNT_W-1:0]  remove_count,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [BYTE_W-1:0]   read_byte,
	output logic                     ok,
	output logic      [COUNT_W-1:0]  removed,
	output logic      [FILL_W-1:0]   fill_count,
	output logic                     full_res
);

	localparam int AW = $clog2(DEPTH);

	logic              accept, cfg_we;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata, rdata_q;
	res_t              res, res_s1;
	logic              valid_s1;

	// handshakes
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_ready  = !valid_s1 || out_ready;
	assign accept    = in_valid && in_ready;

	brb_core #(.DEPTH(DEPTH)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.peek_offset  (peek_offset),
		.remove_count (remove_count),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.res          (res)
	);

	brb_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_q (rdata_q)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// outputs; store data shown only for a valid peek
	assign out_valid  = valid_s1;
	assign read_byte  = res_s1.peek_hit ? rdata_q : '0;
	assign ok         = res_s1.ok;
	assign removed    = res_s1.removed;
	assign fill_count = res_s1.fill;
	assign full_res   = res_s1.full;

endmodule

`default_nettype wire

// ===== sv/brb_store.sv =====
// Byte storage of the ring buffer: one write port, one read port with
// registered read data. Depends on brb_pkg for the byte width.
`default_nettype none

module brb_store
	import brb_pkg::*;
#(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [BYTE_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [BYTE_W-1:0] rdata_q
);

	logic [BYTE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/brb_core.sv =====
// Index core of the ring buffer: size register, read and write indices,
// fill arithmetic, store access and per-request result. Depends on brb_pkg.
`default_nettype none

module brb_core
	import brb_pkg::*;
#(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                accept,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [BYTE_W-1:0]   data_byte,
	input  wire logic [OFFSET_W-1:0] peek_offset,
	input  wire logic [COUNT_W-1:0]  remove_count,
	output logic                     mem_we,
	output logic      [AW-1:0]       mem_waddr,
	output logic      [BYTE_W-1:0]   mem_wdata,
	output logic                     mem_re,
	output logic      [AW-1:0]       mem_raddr,
	output res_t                     res
);

	localparam int SW = $clog2(DEPTH + 1);
	localparam int CW = ((SW > COUNT_W) ? SW : COUNT_W) + 1;
	localparam int SIZE_RST_I = (1024 > DEPTH) ? DEPTH : 1024;
	localparam logic [SW-1:0] SIZE_RST = SW'(SIZE_RST_I);

	logic [SW-1:0] size_q;
	logic [AW-1:0] wi_q, ri_q;
	logic [AW-1:0] wi_d, ri_d;

	logic [CW-1:0] wi_x, ri_x, sz_x, off_x, cnt_x;
	logic [CW-1:0] fill_w, pk_sum, pk_pos, rem_w, rd_sum, rd_new, wi_inc, wi_new;
	logic [CW-1:0] new_fill;
	logic          put_ok, peek_ok;
	logic [31:0]   cfg_v, cfg_clamp;
	op_t           op;

	// widen everything to a common arithmetic width
	assign wi_x  = CW'(wi_q);
	assign ri_x  = CW'(ri_q);
	assign sz_x  = CW'(size_q);
	assign off_x = CW'(peek_offset);
	assign cnt_x = CW'(remove_count);
	assign op    = op_t'(opcode);

	// fill count before the operation
	assign fill_w  = (wi_x >= ri_x) ? (wi_x - ri_x) : (wi_x + sz_x - ri_x);
	assign put_ok  = fill_w < (sz_x - CW'(1));
	assign peek_ok = off_x < fill_w;

	// peek position, wrapped once (offset below fill keeps it under 2*size)
	assign pk_sum = ri_x + off_x;
	assign pk_pos = (pk_sum >= sz_x) ? (pk_sum - sz_x) : pk_sum;

	// remove advances read index by min(count, fill)
	assign rem_w  = (cnt_x < fill_w) ? cnt_x : fill_w;
	assign rd_sum = ri_x + rem_w;
	assign rd_new = (rd_sum >= sz_x) ? (rd_sum - sz_x) : rd_sum;

	// put advances write index by one
	assign wi_inc = wi_x + CW'(1);
	assign wi_new = (wi_inc >= sz_x) ? (wi_inc - sz_x) : wi_inc;

	assign mem_waddr = wi_q;
	assign mem_wdata = data_byte;
	assign mem_raddr = pk_pos[AW-1:0];

	// operation decode and result
	always_comb begin
		wi_d     = wi_q;
		ri_d     = ri_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		new_fill = fill_w;
		res      = '0;
		case (op)
			OP_PUT: begin
				if (put_ok) begin
					mem_we   = accept;
					wi_d     = wi_new[AW-1:0];
					res.ok   = 1'b1;
					new_fill = fill_w + CW'(1);
				end
			end
			OP_PEEK: begin
				if (peek_ok) begin
					mem_re       = accept;
					res.ok       = 1'b1;
					res.peek_hit = 1'b1;
				end
			end
			OP_REMOVE: begin
				ri_d        = rd_new[AW-1:0];
				res.removed = rem_w[COUNT_W-1:0];
				new_fill    = fill_w - rem_w;
			end
			OP_CLEAR: begin
				wi_d     = '0;
				ri_d     = '0;
				new_fill = '0;
			end
			default: begin
				new_fill = fill_w;
			end
		endcase
		res.fill = new_fill[FILL_W-1:0];
		res.full = new_fill == (sz_x - CW'(1));
	end

	// size write clamped to 2..DEPTH
	always_comb begin
		cfg_v = 32'(cfg_data);
		if (cfg_v < 32'd2) begin
			cfg_clamp = 32'd2;
		end else if (cfg_v > 32'(DEPTH)) begin
			cfg_clamp = 32'(DEPTH);
		end else begin
			cfg_clamp = cfg_v;
		end
	end

	// size and index registers; a size write empties the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RST;
			wi_q   <= '0;
			ri_q   <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_clamp[SW-1:0];
			wi_q   <= '0;
			ri_q   <= '0;
		end else if (accept) begin
			wi_q <= wi_d;
			ri_q <= ri_d;
		end
	end

	a_wi_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(wi_q) < sz_x)
		else $error("write index beyond buffer size");

	a_ri_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(ri_q) < sz_x)
		else $error("read index beyond buffer size");

	a_cfg_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (wi_q == '0) && (ri_q == '0))
		else $error("size write did not empty buffer");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for byte_ring_buffer_peek_skip_top: drives put, peek, remove and
// clear requests across several buffer sizes and checks every result against a predictor.
// Depends on brb_pkg and the RTL of the top level.
`default_nettype none

module testbench;
	import brb_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic [BYTE_W-1:0]  rd_byte;
		logic               ok;
		logic [COUNT_W-1:0] removed;
		logic [FILL_W-1:0]  fill;
		logic               full;
	} ring_status_t;

	// Predicts ring buffer status per request and matches returned results in order
	class ring_scoreboard;
		logic [BYTE_W-1:0] slot_data [DEPTH];
		int unsigned       wr_pos;
		int unsigned       rd_pos;
		int unsigned       slots;
		ring_status_t      pending_status [$];
		int unsigned       errors;
		int unsigned       requests;
		int unsigned       refused_puts;
		int unsigned       peak_fill;

		function new();
			slots = DEPTH;
			wr_pos = 0;
			rd_pos = 0;
			errors = 0;
			requests = 0;
			refused_puts = 0;
			peak_fill = 0;
		endfunction

		function int unsigned held_count();
			if (wr_pos >= rd_pos)
				return wr_pos - rd_pos;
			return wr_pos + slots - rd_pos;
		endfunction

		function int unsigned advance(int unsigned base, int unsigned amount);
			int unsigned sum;
			sum = base + amount;
			if (sum >= slots)
				sum -= slots;
			return sum;
		endfunction

		// size write: clamp to 2..DEPTH and empty the buffer
		function void set_slots(logic [CFG_W-1:0] value);
			if (value < 2)
				slots = 2;
			else if (value > DEPTH)
				slots = DEPTH;
			else
				slots = value;
			wr_pos = 0;
			rd_pos = 0;
		endfunction

		function void apply_request(op_t op, logic [BYTE_W-1:0] data,
				logic [OFFSET_W-1:0] offset, logic [COUNT_W-1:0] count);
			ring_status_t want;
			int unsigned  held;
			want = '0;
			held = held_count();
			case (op)
				OP_PUT: begin
					if (held < slots - 1) begin
						slot_data[wr_pos] = data;
						wr_pos = advance(wr_pos, 1);
						want.ok = 1'b1;
					end else begin
						refused_puts++;
					end
				end
				OP_PEEK: begin
					if (offset < held) begin
						want.rd_byte = slot_data[advance(rd_pos, offset)];
						want.ok = 1'b1;
					end
				end
				OP_REMOVE: begin
					want.removed = (count < held) ? count : COUNT_W'(held);
					rd_pos = advance(rd_pos, want.removed);
				end
				default: begin
					wr_pos = 0;
					rd_pos = 0;
				end
			endcase
			held = held_count();
			want.fill = FILL_W'(held);
			want.full = (held == slots - 1);
			if (held > peak_fill)
				peak_fill = held;
			requests++;
			pending_status.push_back(want);
		endfunction

		function void compare(string field, int unsigned want_v, logic [15:0] got_v);
			if (got_v !== want_v[15:0]) begin
				$display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
				errors++;
			end
		endfunction

		function void match_result(logic [BYTE_W-1:0] rd_byte, logic ok_v,
				logic [COUNT_W-1:0] removed_v, logic [FILL_W-1:0] fill_v, logic full_v);
			ring_status_t want;
			if (pending_status.size() == 0) begin
				$display("%0t: result with none expected, fill_count %0d", $time, fill_v);
				errors++;
				return;
			end
			want = pending_status.pop_front();
			compare("read_byte", want.rd_byte, rd_byte);
			compare("ok", want.ok, ok_v);
			compare("removed", want.removed, removed_v);
			compare("fill_count", want.fill, fill_v);
			compare("full_res", want.full, full_v);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode;
	logic [BYTE_W-1:0]   data_byte;
	logic [OFFSET_W-1:0] peek_offset;
	logic [COUNT_W-1:0]  remove_count;
	logic                out_valid;
	logic                out_ready;
	logic [BYTE_W-1:0]   read_byte;
	logic                ok;
	logic [COUNT_W-1:0]  removed;
	logic [FILL_W-1:0]   fill_count;
	logic                full_res;

	ring_scoreboard ring = new();
	bit             calm = 1'b0;
	int unsigned    sizes_written = 0;
	int unsigned    quiet_cycles = 0;

	byte_ring_buffer_peek_skip_top #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.data_byte(data_byte),
		.peek_offset(peek_offset),
		.remove_count(remove_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_byte(read_byte),
		.ok(ok),
		.removed(removed),
		.fill_count(fill_count),
		.full_res(full_res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: random backpressure, none during the calm stretch
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
	end

	// check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ring.match_result(read_byte, ok, removed, fill_count, full_res);
	end

	// watchdog: cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("testbench failed");
			$finish;
		end
	end

	// one request: optional idle gap, then hold valid until accepted
	task automatic send(op_t op, logic [BYTE_W-1:0] data, logic [OFFSET_W-1:0] offset,
			logic [COUNT_W-1:0] count);
		int unsigned gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 10)
			gap = $urandom_range(1, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		data_byte    <= data;
		peek_offset  <= offset;
		remove_count <= count;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ring.apply_request(op, data, offset, count);
	endtask

	// size write once every outstanding result is back
	task automatic write_size(logic [CFG_W-1:0] value);
		in_valid <= 1'b0;
		while (ring.pending_status.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ring.set_slots(value);
		sizes_written++;
		cfg_valid <= 1'b0;
	endtask

	// random requests; deep keeps removes tiny so the buffer can fill up
	task automatic run_random(int unsigned n, int unsigned put_pct, int unsigned clear_pct,
			bit deep);
		int unsigned      roll;
		int unsigned      held;
		int unsigned      rest;
		op_t              op;
		logic [OFFSET_W-1:0] offset;
		logic [COUNT_W-1:0]  count;
		for (int unsigned i = 0; i < n; i++) begin
			held = ring.held_count();
			roll = $urandom_range(0, 99);
			rest = 100 - put_pct - clear_pct;
			if (roll < put_pct)
				op = OP_PUT;
			else if (roll < put_pct + rest * 6 / 10)
				op = OP_PEEK;
			else if (roll < put_pct + rest)
				op = OP_REMOVE;
			else
				op = OP_CLEAR;
			if ($urandom_range(0, 3) == 0)
				offset = OFFSET_W'($urandom_range(0, 1023));
			else
				offset = OFFSET_W'($urandom_range(0, held));
			if (deep)
				count = COUNT_W'($urandom_range(0, 1));
			else case ($urandom_range(0, 3))
				0: count = COUNT_W'($urandom_range(0, 1024));
				1: count = COUNT_W'($urandom_range(0, held + 1));
				default: count = COUNT_W'($urandom_range(0, 3));
			endcase
			send(op, BYTE_W'($urandom_range(0, 255)), offset, count);
		end
	endtask

	initial begin
		in_valid     <= 1'b0;
		opcode       <= OP_PUT;
		data_byte    <= '0;
		peek_offset  <= '0;
		remove_count <= '0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		arst_n       <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size: ordered peeks, out-of-range peeks, removes past the fill
		send(OP_PUT, 8'h00, 0, 0);
		send(OP_PUT, 8'hFF, 0, 0);
		send(OP_PUT, 8'hA5, 0, 0);
		send(OP_PEEK, 8'h00, 0, 0);
		send(OP_PEEK, 8'h00, 1, 0);
		send(OP_PEEK, 8'h00, 2, 0);
		send(OP_PEEK, 8'h00, 3, 0);
		send(OP_PEEK, 8'h00, 1023, 0);
		send(OP_REMOVE, 8'h00, 0, 0);
		send(OP_REMOVE, 8'h00, 0, 1);
		send(OP_PEEK, 8'h00, 0, 0);
		send(OP_REMOVE, 8'h00, 0, 1023);
		send(OP_REMOVE, 8'h00, 0, 1024);
		send(OP_PEEK, 8'h00, 0, 0);
		send(OP_PUT, 8'h5A, 0, 0);
		send(OP_CLEAR, 8'h00, 0, 0);
		send(OP_PEEK, 8'h00, 0, 0);

		// size below range: one byte of capacity, put when full, wrap of the write index
		write_size(0);
		send(OP_PUT, 8'h11, 0, 0);
		send(OP_PUT, 8'h22, 0, 0);
		send(OP_PEEK, 8'h00, 0, 0);
		send(OP_PEEK, 8'h00, 1, 0);
		send(OP_REMOVE, 8'h00, 0, 1024);
		send(OP_PUT, 8'h33, 0, 0);
		send(OP_PEEK, 8'h00, 0, 0);
		send(OP_CLEAR, 8'h00, 0, 0);

		write_size(1);
		run_random(40, 50, 5, 0);
		write_size(3);
		run_random(60, 45, 5, 0);

		// size above range, then fill to the DEPTH-1 byte capacity with a calm stretch in the middle
		write_size(2047);
		run_random(300, 94, 0, 1);
		calm = 1'b1;
		run_random(300, 94, 0, 1);
		calm = 1'b0;
		run_random(600, 94, 0, 1);

		write_size(1025);
		run_random(80, 50, 5, 0);
		write_size(1024);
		run_random(60, 50, 5, 0);
		repeat (3) begin
			write_size(CFG_W'($urandom_range(4, 40)));
			run_random(50, 50, 4, 0);
		end
		write_size(CFG_W'($urandom_range(2, 1023)));
		run_random(285, 70, 3, 0);

		// drain and let the last result settle
		in_valid <= 1'b0;
		while (ring.pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (ring.pending_status.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, ring.pending_status.size());
			ring.errors++;
		end
		$display("covered %0d requests over %0d size writes; %0d puts refused when full",
			ring.requests, sizes_written, ring.refused_puts);
		$display("highest fill level reached: %0d bytes", ring.peak_fill);
		if (ring.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches", ring.errors);
			$display("testbench failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/brb_pkg.sv
sv/brb_store.sv
sv/brb_core.sv
sv/byte_ring_buffer_peek_skip_top.sv
dv/testbench.sv
